// ===== hw/rtl/pci_bar_register_bank_macros.svh =====
// Assertion macros shared by the bank's checker.
`ifndef PCI_BAR_REGISTER_BANK_MACROS_SVH
`define PCI_BAR_REGISTER_BANK_MACROS_SVH

// Same-cycle implication, sampled on the rising edge.
`define PBRB_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising edge.
`define PBRB_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/pbrb_pkg.sv =====
// Package for the PCI BAR register bank: codes, layout constants and functions.
package pbrb_pkg;

   localparam int unsigned NUM_BARS = 6;

   // Commands
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Device kinds (code 3 behaves as data-center)
   localparam logic [1:0] KIND_VENDOR_A   = 2'd0;
   localparam logic [1:0] KIND_CONSUMER   = 2'd1;
   localparam logic [1:0] KIND_DATACENTER = 2'd2;

   // CSR byte addresses (64-bit registers, 8-byte stride)
   localparam logic [4:0] CSR_ADDR_KIND = 5'd0;
   localparam logic [4:0] CSR_ADDR_VRAM = 5'd8;
   localparam logic [4:0] CSR_ADDR_BUS  = 5'd16;

   localparam logic [1:0]  KIND_RESET = KIND_DATACENTER;
   localparam logic [48:0] VRAM_RESET = 49'd0;
   localparam logic [7:0]  BUS_RESET  = 8'd1;

   // Firmware windows
   localparam logic [63:0] MMIO32_BASE    = 64'h0000_0000_E000_0000;
   localparam logic [63:0] MMIO64_BASE    = 64'h0000_2000_0000_0000;
   localparam logic [63:0] MMIO64_SECOND  = 64'h0000_0080_0000_0000;
   localparam logic [63:0] MMIO32_SECOND  = 64'h0000_0000_0100_0000;
   localparam logic [63:0] IO_BASE       = 64'h0000_0000_0000_3000;
   localparam int unsigned MMIO32_SLOT_SHIFT = 25;
   localparam int unsigned MMIO64_SLOT_SHIFT = 40;
   localparam int unsigned IO_SLOT_SHIFT     = 12;

   // Size masks (size - 1)
   localparam logic [63:0] MASK_16M  = 64'h0000_0000_00FF_FFFF;
   localparam logic [63:0] MASK_32M  = 64'h0000_0000_01FF_FFFF;
   localparam logic [63:0] MASK_256M = 64'h0000_0000_0FFF_FFFF;
   localparam logic [63:0] MASK_2M   = 64'h0000_0000_001F_FFFF;
   localparam logic [63:0] MASK_512K = 64'h0000_0000_0007_FFFF;
   localparam logic [63:0] MASK_128  = 64'h0000_0000_0000_007F;
   localparam logic [48:0] VRAM_DEFAULT = 49'h0_0000_1000_0000;

   // Type flag bits in the read-back
   localparam logic [31:0] FLAG_IO   = 32'h1;
   localparam logic [31:0] FLAG_64   = 32'h4;
   localparam logic [31:0] FLAG_PREF = 32'h8;
   localparam logic [31:0] KEEP_IO   = ~32'h3;
   localparam logic [31:0] KEEP_MEM  = ~32'hF;

   typedef struct packed {
      logic        impl;
      logic        io;
      logic        is64;
      logic        pref;
      logic        high;
      logic [63:0] size_mask;
      logic [63:0] base;
   } bar_desc_type;

   // Framebuffer aperture mask: vram rounded up to a power of two, minus one.
   function automatic logic [48:0] fb_mask_of(input logic [48:0] vram);
      logic [48:0] m;
      m = ((vram == '0) ? VRAM_DEFAULT : vram) - 49'd1;
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
      m = m | (m >> 8);
      m = m | (m >> 16);
      m = m | (m >> 32);
      return m;
   endfunction

   function automatic bar_desc_type mem_bar(input logic [63:0] mask, input logic is64,
                                            input logic [63:0] base);
      bar_desc_type d;
      d           = '0;
      d.impl      = 1'b1;
      d.is64      = is64;
      d.pref      = is64;
      d.size_mask = mask;
      d.base      = base;
      return d;
   endfunction

   function automatic bar_desc_type bar_desc_of(input logic [1:0] kind,
                                                input logic [48:0] fb_mask,
                                                input logic [7:0] slot,
                                                input logic [2:0] idx);
      bar_desc_type d;
      logic [63:0]  slot64;
      logic [63:0]  mmio32;
      logic [63:0]  mmio64;
      logic [63:0]  fbm;
      logic         consumer;
      slot64   = {56'd0, slot};
      mmio32   = MMIO32_BASE + (slot64 << MMIO32_SLOT_SHIFT);
      mmio64   = MMIO64_BASE + (slot64 << MMIO64_SLOT_SHIFT);
      fbm      = {15'd0, fb_mask};
      consumer = (kind == KIND_CONSUMER);
      d        = '0;
      if (kind == KIND_VENDOR_A) begin
         case (idx)
            3'd0: d = mem_bar(fbm, 1'b1, mmio64);
            3'd1: d.high = 1'b1;
            3'd2: d = mem_bar(MASK_2M, 1'b1, mmio64 + MMIO64_SECOND);
            3'd3: d.high = 1'b1;
            3'd5: d = mem_bar(MASK_512K, 1'b0, mmio32 + MMIO32_SECOND);
            default: d = '0;
         endcase
      end else begin
         case (idx)
            3'd0: d = mem_bar(MASK_16M, 1'b0, mmio32);
            3'd1: d = mem_bar(consumer ? MASK_256M : fbm, 1'b1, mmio64);
            3'd2: d.high = 1'b1;
            3'd3: d = mem_bar(MASK_32M, 1'b1, mmio64 + MMIO64_SECOND);
            3'd4: d.high = 1'b1;
            3'd5: begin
               if (consumer) begin
                  d.impl      = 1'b1;
                  d.io        = 1'b1;
                  d.size_mask = MASK_128;
                  d.base      = IO_BASE + (slot64 << IO_SLOT_SHIFT);
               end
            end
            default: d = '0;
         endcase
      end
      return d;
   endfunction

   // Read-back of one BAR given its descriptor, the one below it and its stored value.
   function automatic logic [31:0] readback(input bar_desc_type cur,
                                            input bar_desc_type lo,
                                            input logic flag,
                                            input logic [31:0] value);
      logic [31:0] v;
      logic [31:0] flags;
      logic [31:0] keep;
      v     = '0;
      flags = '0;
      keep  = '0;
      if (cur.high) begin
         if (lo.impl && lo.is64) begin
            v = flag ? value : lo.base[63:32];
            v = v & ~lo.size_mask[63:32];
         end
      end else if (cur.impl) begin
         if (cur.io) begin
            flags = FLAG_IO;
            keep  = ~cur.size_mask[31:0] & KEEP_IO;
         end else begin
            flags = (cur.is64 ? FLAG_64 : '0) | (cur.pref ? FLAG_PREF : '0);
            keep  = ~cur.size_mask[31:0] & KEEP_MEM;
         end
         v = ((flag ? value : cur.base[31:0]) & keep) | flags;
      end
      return v;
   endfunction

endpackage

// ===== hw/rtl/pci_bar_register_bank.sv =====
// Top level of the PCI BAR register bank: six sized base address registers.
//
// Six PCI base address registers whose size, type flags and firmware default
// base follow from three control registers (device kind, framebuffer size,
// bus number). Each transfer on the req channel reads or writes one BAR with
// byte enables and returns the BAR's read-back value after the access on the
// rsp channel, one result per request, in order. A new request can be taken
// every cycle while req_stall is low; each request passes the input register,
// then the lookup/merge stage into the result register.
// While a finished result waits on a stalled rsp channel the input register
// takes one more request, then req_stall holds until the result drains.
// Control registers sit on a 64-bit APB-style port at
// byte offsets 0 (kind), 8 (framebuffer bytes) and 16 (bus number); write them
// only while no request is in flight. Layout is derived live from them, so a
// change affects unwritten BARs and the masking of written ones.
module pci_bar_register_bank (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [2:0]  req_bar_index,
   input  logic [3:0]  req_byte_enable,
   input  logic [31:0] req_write_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   // control register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   // ---------------- control registers ----------------
   logic [1:0]  kind_ff,    kind_in;
   logic [48:0] vram_ff,    vram_in;
   logic [48:0] fb_mask_ff, fb_mask_in;   // aperture mask, recomputed on write
   logic [7:0]  bus_ff,     bus_in;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      kind_in    = kind_ff;
      vram_in    = vram_ff;
      fb_mask_in = fb_mask_ff;
      bus_in     = bus_ff;
      if (csr_write) begin
         case (paddr)
            pbrb_pkg::CSR_ADDR_KIND: kind_in = pwdata[1:0];
            pbrb_pkg::CSR_ADDR_VRAM: begin
               vram_in    = pwdata[48:0];
               fb_mask_in = pbrb_pkg::fb_mask_of(pwdata[48:0]);
            end
            pbrb_pkg::CSR_ADDR_BUS:  bus_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= pbrb_pkg::KIND_RESET;
         vram_ff    <= pbrb_pkg::VRAM_RESET;
         fb_mask_ff <= pbrb_pkg::fb_mask_of(pbrb_pkg::VRAM_RESET);
         bus_ff     <= pbrb_pkg::BUS_RESET;
      end else begin
         kind_ff    <= kind_in;
         vram_ff    <= vram_in;
         fb_mask_ff <= fb_mask_in;
         bus_ff     <= bus_in;
      end
   end

   always_comb begin
      case (paddr)
         pbrb_pkg::CSR_ADDR_KIND: prdata = {62'd0, kind_ff};
         pbrb_pkg::CSR_ADDR_VRAM: prdata = {15'd0, vram_ff};
         pbrb_pkg::CSR_ADDR_BUS:  prdata = {56'd0, bus_ff};
         default:                 prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   // Stage 1 holds the accepted request; it moves on when the result
   // register is empty or being drained this cycle.
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_command_ff;
   logic [2:0]  s1_bar_index_ff;
   logic [3:0]  s1_byte_enable_ff;
   logic [31:0] s1_write_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_read_data_ff, rsp_read_data_in;
   logic        req_transfer;
   logic        s1_advance;

   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_transfer = req_valid && !req_stall;
   assign s1_valid_in  = req_transfer || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         s1_command_ff     <= req_command;
         s1_bar_index_ff   <= req_bar_index;
         s1_byte_enable_ff <= req_byte_enable;
         s1_write_data_ff  <= req_write_data;
      end
      if (s1_advance) begin
         rsp_read_data_ff <= rsp_read_data_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;

   // ---------------- BAR state ----------------
   // Stored values have no reset; the flag decides whether they are used.
   logic [31:0] written_value_ff [pbrb_pkg::NUM_BARS];
   logic [pbrb_pkg::NUM_BARS-1:0] written_flag_ff;
   logic [31:0] written_value_in;
   logic        bar_write;

   // ---------------- lookup and merge ----------------
   logic [7:0]             slot;
   logic [2:0]             lo_index;
   logic                   index_ok;
   logic                   cur_flag;
   logic [31:0]            cur_value;
   logic [31:0]            old_readback;
   logic [31:0]            covered;
   pbrb_pkg::bar_desc_type desc_cur;
   pbrb_pkg::bar_desc_type desc_lo;

   // slot is bus - 1, pinned at zero for bus zero
   assign slot     = (bus_ff == 8'd0) ? 8'd0 : bus_ff - 8'd1;
   assign index_ok = (s1_bar_index_ff < 3'(pbrb_pkg::NUM_BARS));
   assign lo_index = s1_bar_index_ff - 3'd1;   // BAR0 never is an upper half
   assign desc_cur = pbrb_pkg::bar_desc_of(kind_ff, fb_mask_ff, slot, s1_bar_index_ff);
   assign desc_lo  = pbrb_pkg::bar_desc_of(kind_ff, fb_mask_ff, slot, lo_index);
   assign cur_flag  = index_ok && written_flag_ff[s1_bar_index_ff];
   assign cur_value = index_ok ? written_value_ff[s1_bar_index_ff] : '0;
   assign old_readback = pbrb_pkg::readback(desc_cur, desc_lo, cur_flag, cur_value);

   always_comb begin
      for (int lane = 0; lane < 4; lane++) begin
         covered[8*lane +: 8] = {8{s1_byte_enable_ff[lane]}};
      end
   end

   // write merges enabled lanes into the current read-back value
   assign written_value_in = (old_readback & ~covered) | (s1_write_data_ff & covered);
   assign bar_write = s1_advance && index_ok && (s1_command_ff == pbrb_pkg::CMD_WRITE);

   always_comb begin
      if (!index_ok) begin
         rsp_read_data_in = '0;               // out-of-range BAR reads zero
      end else if (s1_command_ff == pbrb_pkg::CMD_WRITE) begin
         rsp_read_data_in = pbrb_pkg::readback(desc_cur, desc_lo, 1'b1, written_value_in);
      end else begin
         rsp_read_data_in = old_readback;
      end
   end

   always_ff @(posedge clock) begin
      if (bar_write) begin
         written_value_ff[s1_bar_index_ff] <= written_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_flag_ff <= '0;
      end else if (bar_write) begin
         written_flag_ff[s1_bar_index_ff] <= 1'b1;
      end
   end

endmodule

// ===== hw/rtl/pbrb_checker.sv =====
// Port-level checker for the PCI BAR register bank, bound to the top level.
`include "pci_bar_register_bank_macros.svh"

module pbrb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_read_data
);

   logic rsp_waiting;

   assign rsp_waiting = rsp_valid && rsp_stall;

   // stalled result stays offered
   `PBRB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_waiting, rsp_valid, "rsp dropped")
   // stalled result data holds
   `PBRB_ASSERT_NEXT(a_rsp_data, clock, reset, rsp_waiting, $stable(rsp_read_data), "data moved")
   // with no result pending the request side never stalls
   `PBRB_ASSERT_NOW(a_no_stall, clock, reset, !rsp_valid, !req_stall, "needless req stall")
   // reset empties the pipeline
   `PBRB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !req_stall, "not empty")

endmodule

bind pci_bar_register_bank pbrb_checker u_pbrb_checker (.*);
